// File: design/swrl_pkg.sv
// ---------------------------------------------------------------------------
// swrl_pkg - shared definitions for the sliding window request limiter
// Function codes, severity codes, register indexes, field widths and the
// saturating time add.
// ---------------------------------------------------------------------------
package swrl_pkg;

  localparam int TIME_W = 48;
  localparam int WIN_W  = 32;
  localparam int CNT_W  = 7;
  localparam int FUNC_W = 2;
  localparam int SEV_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [WIN_W-1:0]  win_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SEV_W-1:0]  sev_t;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_NORMAL   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRIORITY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NOTICE   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;

  // severity codes
  localparam sev_t SEV_NONE  = 3'd0;
  localparam sev_t SEV_DEBUG = 3'd1;
  localparam sev_t SEV_INFO  = 3'd2;
  localparam sev_t SEV_WARN  = 3'd3;
  localparam sev_t SEV_ERROR = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_STEP   = 2'd2;

  localparam cnt_t  RST_MAX_REQUESTS  = 7'd10;
  localparam win_t  RST_WINDOW_LENGTH = 32'd1000000;
  localparam win_t  RST_REPORT_STEP   = 32'd100000;

  // a + b, clipped at the largest timestamp
  function automatic time_t sat_add(input time_t a, input win_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W-WIN_W+1){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// File: design/sliding_window_request_limiter_unit.sv
// ---------------------------------------------------------------------------
// sliding_window_request_limiter_unit - sliding window log rate limiter
// Keeps a ring of past grant times in RAM, drops expired entries, grants or
// delays normal requests, appends priority requests and penalty fills.
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   func, now
//  out      out_valid / out_stall grant_time, severity, occupancy
//  cfg      cfg_we                cfg_index, cfg_data
//
//  One item at a time: a flush drops expired entries from the oldest end
//  (single RAM read port; none when the ring is or runs empty), then a decide
//  step and the appends (one a cycle, RAM write port; up to capacity for a
//  notice). A normal request ends with grade and severity steps; on a full
//  ring it flushes again against its grant time before it appends. An unused
//  code goes straight to the result. Sync reset empties the ring; no clearing
//  pass, RAM content is don't care. in_stall is high while an item is in work;
//  out holds until taken, and the next item is accepted meanwhile.
// ---------------------------------------------------------------------------
module sliding_window_request_limiter_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [swrl_pkg::FUNC_W-1:0]         func,
  input  logic [swrl_pkg::TIME_W-1:0]         now,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [swrl_pkg::TIME_W-1:0]         grant_time,
  output logic [swrl_pkg::SEV_W-1:0]          severity,
  output logic [swrl_pkg::CNT_W-1:0]          occupancy,
  // configuration
  input  logic                                cfg_we,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUM_W   = ((IDX_W > swrl_pkg::CNT_W) ? IDX_W : swrl_pkg::CNT_W) + 1;
  localparam int CAP_LIM = (MAX_ENTRIES > 127) ? 127 : MAX_ENTRIES;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FLUSH  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_GRADE  = 3'd4;
  localparam logic [2:0] S_SEV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                  state;
  logic [swrl_pkg::FUNC_W-1:0] func_q;
  swrl_pkg::time_t             now_q;
  swrl_pkg::time_t             t_q;      // flush threshold
  swrl_pkg::time_t             val_q;    // value to append
  swrl_pkg::time_t             grant_q;
  swrl_pkg::time_t             head_q;   // oldest entry after a flush
  swrl_pkg::time_t             delay_q;
  swrl_pkg::sev_t              sev_q;
  logic                        pass_q;   // second flush pass taken

  logic [IDX_W-1:0]            oldest;
  swrl_pkg::cnt_t              count;
  swrl_pkg::cnt_t              max_requests;
  swrl_pkg::win_t              window_length;
  swrl_pkg::win_t              report_step;

  // RAM ports
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [IDX_W-1:0]            ram_raddr;
  swrl_pkg::time_t             ram_rdata;

  swrl_ram #(
    .WIDTH (swrl_pkg::TIME_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // derived values
  swrl_pkg::cnt_t              cap;
  logic [IDX_W-1:0]            oldest_inc;
  logic [SUM_W-1:0]            tail_sum;
  logic                        full;
  logic                        expired;
  logic                        in_accept;
  logic                        out_free;
  swrl_pkg::cnt_t              count_push;
  swrl_pkg::time_t             notice_base;
  logic [swrl_pkg::WIN_W+2:0]  step6;
  logic [swrl_pkg::WIN_W+2:0]  step4;
  logic [swrl_pkg::WIN_W+2:0]  step2;
  swrl_pkg::sev_t              sev_next;

  always_comb begin
    if (max_requests == '0) begin
      cap = 7'd1;
    end else if (max_requests > 7'(CAP_LIM)) begin
      cap = 7'(CAP_LIM);
    end else begin
      cap = max_requests;
    end
  end

  assign oldest_inc = (oldest == IDX_W'(MAX_ENTRIES - 1)) ? '0 : oldest + 1'b1;
  assign tail_sum   = SUM_W'(oldest) + SUM_W'(count);
  assign ram_waddr  = (tail_sum >= SUM_W'(MAX_ENTRIES))
                    ? IDX_W'(tail_sum - SUM_W'(MAX_ENTRIES))
                    : IDX_W'(tail_sum);
  assign full       = (count >= cap);
  assign count_push = full ? count : count + 1'b1;
  assign expired    = ({1'b0, ram_rdata} + (swrl_pkg::TIME_W+1)'(window_length))
                      <= {1'b0, t_q};
  assign in_accept  = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign notice_base = swrl_pkg::sat_add((count != '0) ? head_q : now_q, window_length);
  assign ram_we     = (state == S_PUSH);
  assign ram_raddr  = (state == S_FLUSH && expired) ? oldest_inc : oldest;

  // severity multiples of the step
  assign step2 = {2'b00, report_step, 1'b0};
  assign step4 = {1'b0, report_step, 2'b00};
  assign step6 = step4 + step2;

  always_comb begin
    if (delay_q < swrl_pkg::TIME_W'(report_step)) begin
      sev_next = swrl_pkg::SEV_NONE;
    end else if (delay_q > swrl_pkg::TIME_W'(step6)) begin
      sev_next = swrl_pkg::SEV_ERROR;
    end else if (delay_q > swrl_pkg::TIME_W'(step4)) begin
      sev_next = swrl_pkg::SEV_WARN;
    end else if (delay_q > swrl_pkg::TIME_W'(step2)) begin
      sev_next = swrl_pkg::SEV_INFO;
    end else begin
      sev_next = swrl_pkg::SEV_DEBUG;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          func_q  <= func;
          now_q   <= now;
          t_q     <= now;
          val_q   <= now;
          grant_q <= now;
          sev_q   <= swrl_pkg::SEV_NONE;
        end
      end
      S_FLUSH: begin
        if (!expired) begin
          head_q <= ram_rdata;
        end
      end
      S_DECIDE: begin
        if (!pass_q) begin
          if (func_q == swrl_pkg::FUNC_NORMAL && full) begin
            grant_q <= swrl_pkg::sat_add(head_q, window_length);
            t_q     <= swrl_pkg::sat_add(head_q, window_length);
            val_q   <= swrl_pkg::sat_add(head_q, window_length);
          end else if (func_q == swrl_pkg::FUNC_NOTICE) begin
            val_q <= notice_base;
          end
        end
      end
      S_GRADE: delay_q <= grant_q - now_q;
      S_SEV:   sev_q   <= sev_next;
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pass_q        <= 1'b0;
      oldest        <= '0;
      count         <= '0;
      max_requests  <= swrl_pkg::RST_MAX_REQUESTS;
      window_length <= swrl_pkg::RST_WINDOW_LENGTH;
      report_step   <= swrl_pkg::RST_REPORT_STEP;
      out_valid     <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            pass_q <= 1'b0;
            if (func == swrl_pkg::FUNC_UNUSED) begin
              state <= S_DONE;
            end else if (count == '0) begin
              state <= S_DECIDE;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (expired) begin
            oldest <= oldest_inc;
            count  <= count - 1'b1;
            if (count == 7'd1) begin
              state <= S_DECIDE;
            end
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // a delayed normal request flushes again against its grant time
          if (!pass_q && func_q == swrl_pkg::FUNC_NORMAL && full) begin
            pass_q <= 1'b1;
            state  <= S_FLUSH;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (full) begin
            oldest <= oldest_inc;
          end
          count <= count_push;
          if (func_q == swrl_pkg::FUNC_NOTICE && count_push < cap) begin
            state <= S_PUSH;
          end else if (func_q == swrl_pkg::FUNC_NORMAL) begin
            state <= S_GRADE;
          end else begin
            state <= S_DONE;
          end
        end
        S_GRADE: state <= S_SEV;
        S_SEV:   state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // the user writes these only while idle; the block itself does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          swrl_pkg::REG_MAX_REQUESTS: begin
            max_requests <= cfg_data[swrl_pkg::CNT_W-1:0];
            oldest       <= '0;
            count        <= '0;
          end
          swrl_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
          swrl_pkg::REG_REPORT_STEP:   report_step   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      grant_time <= grant_q;
      severity   <= sev_q;
      occupancy  <= count;
    end
  end

endmodule

// File: design/swrl_ram.sv
// ---------------------------------------------------------------------------
// swrl_ram - simple dual port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module swrl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
